@@ design/ctrp_pkg.sv @@
// Shared constants, types and layout functions of the tracker report parser.
package ctrp_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int TIMER_WIDTH  = 32;
	localparam int CFG_W        = 32;
	localparam int CMP_W        = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int LEN_W        = 5;

	localparam logic [7:0] HDR_A0 = 8'hA0;
	localparam logic [7:0] HDR_A1 = 8'hA1;
	localparam logic [7:0] HDR_A2 = 8'hA2;
	localparam logic [7:0] HDR_A3 = 8'hA3;
	localparam logic [7:0] HDR_A4 = 8'hA4;
	localparam logic [7:0] HDR_A5 = 8'hA5;
	localparam logic [7:0] HDR_A6 = 8'hA6;

	localparam logic [7:0]       CHECK_BASE    = 8'h40;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(2000000);

	typedef enum logic [2:0] {
		KIND_CHANNEL   = 3'd0,
		KIND_ECHO      = 3'd1,
		KIND_CHECK_ERR = 3'd2,
		KIND_UNHANDLED = 3'd3,
		KIND_TIMEOUT   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_EMIT
	} seq_state_t;

	// Watchdog controls from the sequencer
	typedef struct packed {
		logic tick;
		logic restart;
	} wd_ctl_t;

	// Total report length for a header byte, zero for a non-header
	function automatic logic [LEN_W-1:0] hdr_length(input logic [7:0] b);
		logic [LEN_W-1:0] len;
		case (b)
			HDR_A0: len = LEN_W'(15);
			HDR_A1: len = LEN_W'(18);
			HDR_A2: len = LEN_W'(30);
			HDR_A3: len = LEN_W'(18);
			HDR_A4: len = LEN_W'(4);
			HDR_A5: len = LEN_W'(5);
			HDR_A6: len = LEN_W'(26);
			default: len = '0;
		endcase
		return len;
	endfunction

	// Number of results a good report of this type yields
	function automatic logic [3:0] chan_count(input logic [7:0] rtype);
		logic [3:0] n;
		case (rtype)
			HDR_A0: n = 4'd4;
			HDR_A1: n = 4'd5;
			HDR_A2, HDR_A6: n = 4'd8;
			HDR_A4: n = 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Byte offset of the first byte of a channel in the report
	function automatic logic [LEN_W-1:0] chan_start(input logic [7:0] rtype,
		input logic [2:0] ch);
		logic [LEN_W-1:0] s;
		case (ch)
			3'd0: s = LEN_W'(2);
			3'd1: s = LEN_W'(5);
			3'd2: s = LEN_W'(8);
			3'd3: s = LEN_W'(11);
			3'd4: s = LEN_W'(14);
			3'd5: s = LEN_W'(17);
			3'd6: s = (rtype == HDR_A2) ? LEN_W'(21) : LEN_W'(19);
			3'd7: s = (rtype == HDR_A2) ? LEN_W'(25) : LEN_W'(21);
			default: s = '0;
		endcase
		return s;
	endfunction

	// Bytes fetched for a channel: fraction then mm for A2 x and y
	function automatic logic [2:0] chan_nbytes(input logic [7:0] rtype,
		input logic [2:0] ch);
		logic [2:0] n;
		if (rtype == HDR_A4) begin
			n = 3'd1;
		end else if (ch < 3'd5) begin
			n = 3'd3;
		end else if (rtype == HDR_A2 && ch != 3'd7) begin
			n = 3'd4;
		end else begin
			n = 3'd2;
		end
		return n;
	endfunction

	// Types that decode into channel or echo results
	function automatic logic is_decodable(input logic [7:0] rtype);
		return rtype == HDR_A0 || rtype == HDR_A1 || rtype == HDR_A2 ||
			rtype == HDR_A4 || rtype == HDR_A6;
	endfunction

endpackage

@@ design/ctrp_channels.sv @@
// Handshake channel interfaces for the parser's input and result streams.
interface ctrp_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] rx_byte;

	modport source(output valid, output func, output rx_byte, input ready);
	modport sink(input valid, input func, input rx_byte, output ready);
endinterface

interface ctrp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  report_type;
	logic [7:0]  camera_id;
	logic [2:0]  channel_index;
	logic [23:0] raw_value;
	logic [15:0] fraction;
	logic        last;

	modport source(output valid, output kind, output report_type, output camera_id,
		output channel_index, output raw_value, output fraction, output last,
		input ready);
	modport sink(input valid, input kind, input report_type, input camera_id,
		input channel_index, input raw_value, input fraction, input last,
		output ready);
endinterface

@@ design/ctrp_watchdog.sv @@
// Tick watchdog: timeout register, saturating tick counter and expiry compare.
module ctrp_watchdog import ctrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  wd_ctl_t          ctl,
	output logic             expired
);

	logic [CFG_W-1:0]       timeout_q;
	logic [TIMER_WIDTH-1:0] tick_q;
	logic [TIMER_WIDTH-1:0] tick_inc;

	// Hold the timeout limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Saturating increment and compare against the limit
	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + TIMER_WIDTH'(1);
	assign expired  = CMP_W'(tick_inc) > CMP_W'(timeout_q);

	// Restart on a header or an unhandled report, advance on tick, drop to zero on expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (ctl.restart) begin
			tick_q <= '0;
		end else if (ctl.tick) begin
			tick_q <= expired ? '0 : tick_inc;
		end
	end

endmodule

@@ design/camera_tracker_report_parser.sv @@
// Top level of the tracker report parser: deframer, report buffer and result sequencer.
//
// Usage: in_ch carries one item per request, either a received serial byte
// (func 0, rx_byte) or one time tick (func 1). out_ch carries result requests:
// one per channel of a good report, one echo result, or one status result for
// a bad check byte, an unhandled type or a watchdog timeout; last marks the
// final result caused by an item. cfg_we/cfg_wdata write the timeout limit in
// ticks; the user must write it only while the block is idle, and the block
// itself does not enforce that. Flow: every item passes a take step and an
// execute step. The final byte of a good report then walks the channels,
// reading the report buffer one byte a cycle: a channel of 1 to 4 bytes is
// fetched, then emitted. The buffer read port sets the pace of the walk.
// in_ch is not ready until the walk is over.
// Reset: syncing, watchdog cleared, timeout limit 2000000; the buffer needs
// no clearing pass. A result waits in the output register while the
// receiver stalls; the sequencer holds until that register frees.
module camera_tracker_report_parser import ctrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ctrp_in_if.sink          in_ch,
	ctrp_out_if.source       out_ch,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	seq_state_t state_q, state_next;

	logic             func_q;
	logic [7:0]       byte_q;
	logic             mode_rd_q;
	logic [LEN_W-1:0] byte_cnt_q;
	logic [LEN_W-1:0] exp_len_q;
	logic [7:0]       sum_q;
	logic [7:0]       type_q;
	logic [7:0]       cam_q;
	kind_t            kind_q;
	logic [2:0]       ch_q;
	logic [2:0]       k_q;
	logic             pend_q;
	logic [31:0]      acc_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       mem [BUFFER_DEPTH];

	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [7:0]       out_type_q;
	logic [7:0]       out_cam_q;
	logic [2:0]       out_ch_q;
	logic [23:0]      out_raw_q;
	logic [15:0]      out_frac_q;
	logic             out_last_q;

	logic [LEN_W-1:0]  hdr_len;
	logic              is_header;
	logic              body_more;
	logic              check_ok;
	logic              decodable;
	logic [2:0]        n_bytes;
	logic              fetch_done;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              mem_we;
	logic              out_load;
	logic              wd_expired;
	wd_ctl_t           wd_ctl;

	kind_t             res_kind;
	logic [7:0]        res_type;
	logic [7:0]        res_cam;
	logic [2:0]        res_ch;
	logic [23:0]       res_raw;
	logic [15:0]       res_frac;
	logic              res_last;

	ctrp_watchdog u_watchdog (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (wd_ctl),
		.expired   (wd_expired)
	);

	// Decode the held item
	assign hdr_len    = hdr_length(byte_q);
	assign is_header  = hdr_len != '0;
	assign body_more  = ({1'b0, byte_cnt_q} + (LEN_W+1)'(1)) < {1'b0, exp_len_q};
	assign check_ok   = byte_q == 8'(CHECK_BASE - sum_q);
	assign decodable  = is_decodable(type_q);
	assign n_bytes    = chan_nbytes(type_q, ch_q);
	assign fetch_done = k_q == n_bytes;
	assign rd_addr    = ADDR_W'(chan_start(type_q, ch_q) + LEN_W'(k_q));
	assign wr_addr    = is_header && !mode_rd_q ? '0 : ADDR_W'(byte_cnt_q);

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (func_q) begin
					state_next = wd_expired ? ST_EMIT : ST_IDLE;
				end else if (!mode_rd_q || body_more) begin
					state_next = ST_IDLE;
				end else if (check_ok && decodable) begin
					state_next = ST_FETCH;
				end else begin
					state_next = ST_EMIT;
				end
			end
			ST_FETCH: begin
				if (fetch_done) begin
					state_next = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_next = res_last ? ST_IDLE : ST_FETCH;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ch.ready    = state_q == ST_IDLE;
		wd_ctl.tick    = state_q == ST_EXEC && func_q;
		wd_ctl.restart = state_q == ST_EXEC && !func_q &&
			((!mode_rd_q && is_header) ||
			(mode_rd_q && !body_more && check_ok && !decodable));
		mem_we         = state_q == ST_EXEC && !func_q &&
			((!mode_rd_q && is_header) || (mode_rd_q && body_more));
		out_load       = state_q == ST_EMIT && (!out_valid_q || out_ch.ready);
	end

	// Assemble the pending result
	always_comb begin
		res_kind = kind_q;
		res_type = (kind_q == KIND_TIMEOUT) ? 8'h00 : type_q;
		res_cam  = (kind_q == KIND_TIMEOUT) ? 8'h00 : cam_q;
		res_ch   = (kind_q == KIND_CHANNEL) ? ch_q : 3'd0;
		res_raw  = 24'h0;
		res_frac = 16'h0;
		if (kind_q == KIND_CHANNEL || kind_q == KIND_ECHO) begin
			if (n_bytes == 3'd4) begin
				res_raw  = {8'h00, acc_q[15:0]};
				res_frac = acc_q[31:16];
			end else begin
				res_raw  = acc_q[23:0];
			end
		end
		res_last = kind_q != KIND_CHANNEL || {1'b0, ch_q} == chan_count(type_q) - 4'd1;
	end

	// Sequencer state and framing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_rd_q  <= 1'b0;
			byte_cnt_q <= '0;
			exp_len_q  <= '0;
			sum_q      <= '0;
			pend_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			pend_q  <= state_q == ST_FETCH && !fetch_done;
			if (state_q == ST_EXEC) begin
				if (func_q) begin
					if (wd_expired) begin
						mode_rd_q  <= 1'b0;
						byte_cnt_q <= '0;
					end
				end else if (!mode_rd_q) begin
					if (is_header) begin
						mode_rd_q  <= 1'b1;
						byte_cnt_q <= LEN_W'(1);
						exp_len_q  <= hdr_len;
						sum_q      <= byte_q;
					end
				end else if (body_more) begin
					sum_q      <= sum_q + byte_q;
					byte_cnt_q <= byte_cnt_q + LEN_W'(1);
				end else begin
					mode_rd_q  <= 1'b0;
					byte_cnt_q <= '0;
				end
			end
		end
	end

	// Item capture, header fields and channel walk
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_q <= in_ch.func;
			byte_q <= in_ch.rx_byte;
		end
		if (mem_we && !mode_rd_q) begin
			type_q <= byte_q;
		end
		if (mem_we && mode_rd_q && byte_cnt_q == LEN_W'(1)) begin
			cam_q <= byte_q;
		end
		case (state_q)
			ST_EXEC: begin
				ch_q  <= 3'd0;
				k_q   <= 3'd0;
				acc_q <= '0;
				if (func_q) begin
					kind_q <= KIND_TIMEOUT;
				end else if (!check_ok) begin
					kind_q <= KIND_CHECK_ERR;
				end else if (!decodable) begin
					kind_q <= KIND_UNHANDLED;
				end else if (type_q == HDR_A4) begin
					kind_q <= KIND_ECHO;
				end else begin
					kind_q <= KIND_CHANNEL;
				end
			end
			ST_FETCH: begin
				if (!fetch_done) begin
					k_q <= k_q + 3'd1;
				end
				if (pend_q) begin
					acc_q <= {acc_q[23:0], rd_data_q};
				end
			end
			ST_EMIT: begin
				if (out_load && !res_last) begin
					ch_q  <= ch_q + 3'd1;
					k_q   <= 3'd0;
					acc_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Report buffer: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= byte_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= res_kind;
			out_type_q <= res_type;
			out_cam_q  <= res_cam;
			out_ch_q   <= res_ch;
			out_raw_q  <= res_raw;
			out_frac_q <= res_frac;
			out_last_q <= res_last;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.kind          = out_kind_q;
	assign out_ch.report_type   = out_type_q;
	assign out_ch.camera_id     = out_cam_q;
	assign out_ch.channel_index = out_ch_q;
	assign out_ch.raw_value     = out_raw_q;
	assign out_ch.fraction      = out_frac_q;
	assign out_ch.last          = out_last_q;

	// While reading a report the fill count stays below its length
	a_cnt_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		mode_rd_q |-> byte_cnt_q < exp_len_q)
		else $error("byte count reached report length while reading");

	// Result walk only runs after the frame has closed
	a_walk_synced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH || state_q == ST_EMIT) |-> !mode_rd_q)
		else $error("result walk while a report is still open");

	// The final result hands control back to the input side
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_last) |=> state_q == ST_IDLE)
		else $error("sequencer busy after final result");

	// Byte fetch never runs past the channel width
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> k_q <= n_bytes)
		else $error("fetch index beyond channel width");

endmodule
